// ----- hdl/ccr_pkg.sv -----
package ccr_pkg;

  localparam int COORD_W = 12;
  localparam int T_W     = 16;
  localparam int POINT_W = 21;
  localparam int SEG_W   = 5;
  localparam int CNT_W   = 6;
  localparam int IDX_W   = 5;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_e;

  // one control node, x in the lowest bits
  typedef struct packed {
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } node_t;

  // load enables of the blend stages
  typedef struct packed {
    logic coef;
    logic prod;
    logic sum;
  } pipe_en_t;

endpackage

// ----- hdl/ccr_node_mem.sv -----
module ccr_node_mem
  import ccr_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  node_t                    wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output node_t                    rdata_a_o,
  output node_t                    rdata_b_o
);

  node_t mem [DEPTH];
  node_t rdata_a_q, rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read-old on a same-edge write; data holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem[raddr_a_i];
      rdata_b_q <= mem[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ----- hdl/ccr_axis_blend.sv -----
module ccr_axis_blend
  import ccr_pkg::*;
(
  input  logic                      clk_i,
  input  pipe_en_t                  en_i,
  input  logic signed [COORD_W-1:0] p0_i,
  input  logic signed [COORD_W-1:0] p1_i,
  input  logic signed [COORD_W-1:0] p2_i,
  input  logic signed [COORD_W-1:0] p3_i,
  input  logic [T_W-1:0]            t_i,
  input  logic [T_W-1:0]            t2_i,
  input  logic [T_W-1:0]            t3_i,
  output logic signed [POINT_W-1:0] point_o
);

  localparam int C1_W  = COORD_W + 1;
  localparam int C_W   = COORD_W + 4;
  localparam int TS_W  = T_W + 1;
  localparam int M1_W  = C1_W + TS_W;
  localparam int M_W   = C_W + TS_W;
  localparam int SUM_W = M_W + 2;
  localparam int FRAC_SH = 9;

  logic signed [COORD_W-1:0] p1_c_q, p1_m_q;
  logic signed [C1_W-1:0]    c1_d, c1_q;
  logic signed [C_W-1:0]     c2_d, c2_q, c3_d, c3_q;
  logic signed [C_W-1:0]     e0, e1, e2, e3;
  logic signed [TS_W-1:0]    t_s, t2_s, t3_s;
  logic signed [M1_W-1:0]    m1_d, m1_q;
  logic signed [M_W-1:0]     m2_d, m2_q, m3_d, m3_q;
  logic signed [SUM_W-1:0]   sum;
  logic signed [POINT_W-1:0] point_q;

  assign e0 = C_W'(p0_i);
  assign e1 = C_W'(p1_i);
  assign e2 = C_W'(p2_i);
  assign e3 = C_W'(p3_i);

  assign c1_d = C1_W'(p2_i) - C1_W'(p0_i);
  // 2p0 - 5p1 + 4p2 - p3
  assign c2_d = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
  // -p0 + 3p1 - 3p2 + p3
  assign c3_d = e3 - e0 + (e1 <<< 1) + e1 - (e2 <<< 1) - e2;

  always_ff @(posedge clk_i) begin
    if (en_i.coef) begin
      p1_c_q <= p1_i;
      c1_q   <= c1_d;
      c2_q   <= c2_d;
      c3_q   <= c3_d;
    end
  end

  assign t_s  = $signed({1'b0, t_i});
  assign t2_s = $signed({1'b0, t2_i});
  assign t3_s = $signed({1'b0, t3_i});

  assign m1_d = M1_W'(c1_q) * M1_W'(t_s);
  assign m2_d = M_W'(c2_q) * M_W'(t2_s);
  assign m3_d = M_W'(c3_q) * M_W'(t3_s);

  always_ff @(posedge clk_i) begin
    if (en_i.prod) begin
      p1_m_q <= p1_c_q;
      m1_q   <= m1_d;
      m2_q   <= m2_d;
      m3_q   <= m3_d;
    end
  end

  // 2*p1 in 0.16 units is p1 << 17; halving and 1/256 scaling is a floor shift by 9
  assign sum = (SUM_W'(p1_m_q) <<< (T_W + 1)) + SUM_W'(m1_q) + SUM_W'(m2_q) + SUM_W'(m3_q);

  always_ff @(posedge clk_i) begin
    if (en_i.sum) begin
      point_q <= sum[FRAC_SH +: POINT_W];
    end
  end

  assign point_o = point_q;

endmodule

// ----- hdl/closed_catmull_rom_evaluator.sv -----
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: node_index, node_x/y/z, loop_fraction
//                                             tuser: operation
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: point_x/y/z, segment
// cfg       in   cfg_valid_i/cfg_ready_o      cfg_data_i: node_count
//
// one item per cycle unless m_axis_tready back-pressure stalls; m_axis_tvalid rises after an evaluate transfer
// (five registers: phase multiply at the transfer edge, node read, coefficients, products, sum)
// the four node reads go through two copies of the node memory, two read ports each
// a load writes both copies at its transfer edge and gives no result
// reset clears the pipeline and sets node_count to 18; node memory is not cleared
// back-pressure stalls only the stages behind a full one, so bubbles are absorbed
module closed_catmull_rom_evaluator
  import ccr_pkg::*;
#(
  parameter int MAX_NODES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [4:0] node_index, [16:5] node_x, [28:17] node_y, [40:29] node_z,
  // [56:41] loop_fraction
  input  logic [63:0] s_axis_tdata,
  // [0] operation
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [20:0] point_x, [41:21] point_y, [62:42] point_z, [67:63] segment
  output logic [71:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [5:0]  cfg_data_i
);

  localparam int AW = $clog2(MAX_NODES);
  localparam int NW = $clog2(MAX_NODES + 1);
  localparam int PW = T_W + NW;
  localparam int COUNT_MIN   = 4;
  localparam int COUNT_RESET = 18;

  function automatic logic [NW-1:0] clamp_count(input logic [CNT_W-1:0] c);
    logic [31:0] v;
    v = 32'(c);
    if (v < COUNT_MIN) v = COUNT_MIN;
    if (v > MAX_NODES) v = MAX_NODES;
    return v[NW-1:0];
  endfunction

  // input unpack
  op_e                 op;
  logic [IDX_W-1:0]    node_index;
  node_t               node_in;
  logic [T_W-1:0]      loop_fraction;
  logic [31:0]         index_ext;

  assign op            = op_e'(s_axis_tuser[0]);
  assign node_index    = s_axis_tdata[4:0];
  assign node_in.x     = s_axis_tdata[16:5];
  assign node_in.y     = s_axis_tdata[28:17];
  assign node_in.z     = s_axis_tdata[40:29];
  assign loop_fraction = s_axis_tdata[56:41];
  assign index_ext     = 32'(node_index);

  // node count register
  logic [NW-1:0] n_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= clamp_count(CNT_W'(COUNT_RESET));
    end else if (cfg_valid_i) begin
      n_q <= clamp_count(cfg_data_i);
    end
  end

  // stage valids and ready chain
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic s_xfer, eval_xfer, load_we;

  assign rdy5 = !v5_q || m_axis_tready;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  // loads wait too, so a stalled evaluate never reads a node written after it
  assign s_axis_tready = rdy1;
  assign s_xfer    = s_axis_tvalid && s_axis_tready;
  assign eval_xfer = s_xfer && (op == OP_EVAL);
  assign load_we   = s_xfer && (op == OP_LOAD) && (index_ext < MAX_NODES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= eval_xfer;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
    end
  end

  // stage 1: phase = u * n split into segment and t
  logic [PW-1:0]  phase;
  logic [NW-1:0]  i1_q;
  logic [T_W-1:0] t1_q;

  assign phase = PW'(loop_fraction) * PW'(n_q);

  always_ff @(posedge clk_i) begin
    if (eval_xfer) begin
      i1_q <= phase[PW-1:T_W];
      t1_q <= phase[T_W-1:0];
    end
  end

  // neighbor indexes around the ring
  logic [NW:0]   i_p1, i_p2, n_x;
  logic [NW:0]   a1_w, a2_w;
  logic [NW-1:0] a0_w;
  logic [AW-1:0] addr0, addr1, addr2, addr3;
  logic          rd_en;

  assign n_x  = {1'b0, n_q};
  assign i_p1 = {1'b0, i1_q} + (NW+1)'(1);
  assign i_p2 = {1'b0, i1_q} + (NW+1)'(2);
  assign a1_w = (i_p1 >= n_x) ? i_p1 - n_x : i_p1;
  assign a2_w = (i_p2 >= n_x) ? i_p2 - n_x : i_p2;
  assign a0_w = (i1_q == '0) ? n_q - NW'(1) : i1_q - NW'(1);

  assign addr0 = a0_w[AW-1:0];
  assign addr1 = i1_q[AW-1:0];
  assign addr2 = a1_w[AW-1:0];
  assign addr3 = a2_w[AW-1:0];
  assign rd_en = v1_q && rdy2;

  node_t nd0, nd1, nd2, nd3;

  ccr_node_mem #(.DEPTH(MAX_NODES)) u_mem_lo (
    .clk_i     (clk_i),
    .we_i      (load_we),
    .waddr_i   (index_ext[AW-1:0]),
    .wdata_i   (node_in),
    .re_i      (rd_en),
    .raddr_a_i (addr0),
    .raddr_b_i (addr1),
    .rdata_a_o (nd0),
    .rdata_b_o (nd1)
  );

  ccr_node_mem #(.DEPTH(MAX_NODES)) u_mem_hi (
    .clk_i     (clk_i),
    .we_i      (load_we),
    .waddr_i   (index_ext[AW-1:0]),
    .wdata_i   (node_in),
    .re_i      (rd_en),
    .raddr_a_i (addr2),
    .raddr_b_i (addr3),
    .rdata_a_o (nd2),
    .rdata_b_o (nd3)
  );

  // stage 2: t^2
  logic [2*T_W-1:0] tt_prod, ttt_prod;
  logic [T_W-1:0]   t2_q, tt2_q;
  logic [NW-1:0]    seg2_q;

  assign tt_prod = (2*T_W)'(t1_q) * (2*T_W)'(t1_q);

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      t2_q   <= t1_q;
      tt2_q  <= tt_prod[2*T_W-1:T_W];
      seg2_q <= i1_q;
    end
  end

  // stage 3: t^3
  logic [T_W-1:0] t3_q, tt3_q, ttt3_q;
  logic [NW-1:0]  seg3_q, seg4_q, seg5_q;
  pipe_en_t       en;

  assign en.coef = v2_q && rdy3;
  assign en.prod = v3_q && rdy4;
  assign en.sum  = v4_q && rdy5;

  assign ttt_prod = (2*T_W)'(tt2_q) * (2*T_W)'(t2_q);

  always_ff @(posedge clk_i) begin
    if (en.coef) begin
      t3_q   <= t2_q;
      tt3_q  <= tt2_q;
      ttt3_q <= ttt_prod[2*T_W-1:T_W];
      seg3_q <= seg2_q;
    end
    if (en.prod) begin
      seg4_q <= seg3_q;
    end
    if (en.sum) begin
      seg5_q <= seg4_q;
    end
  end

  logic signed [POINT_W-1:0] point_x, point_y, point_z;

  ccr_axis_blend u_blend_x (
    .clk_i   (clk_i),
    .en_i    (en),
    .p0_i    (nd0.x),
    .p1_i    (nd1.x),
    .p2_i    (nd2.x),
    .p3_i    (nd3.x),
    .t_i     (t3_q),
    .t2_i    (tt3_q),
    .t3_i    (ttt3_q),
    .point_o (point_x)
  );

  ccr_axis_blend u_blend_y (
    .clk_i   (clk_i),
    .en_i    (en),
    .p0_i    (nd0.y),
    .p1_i    (nd1.y),
    .p2_i    (nd2.y),
    .p3_i    (nd3.y),
    .t_i     (t3_q),
    .t2_i    (tt3_q),
    .t3_i    (ttt3_q),
    .point_o (point_y)
  );

  ccr_axis_blend u_blend_z (
    .clk_i   (clk_i),
    .en_i    (en),
    .p0_i    (nd0.z),
    .p1_i    (nd1.z),
    .p2_i    (nd2.z),
    .p3_i    (nd3.z),
    .t_i     (t3_q),
    .t2_i    (tt3_q),
    .t3_i    (ttt3_q),
    .point_o (point_z)
  );

  logic [31:0] seg_ext;

  assign seg_ext       = 32'(seg5_q);
  assign m_axis_tvalid = v5_q;
  assign m_axis_tdata  = {4'b0, seg_ext[SEG_W-1:0], point_z, point_y, point_x};

  a_eval_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    eval_xfer |=> v1_q)
    else $error("evaluate transfer did not enter the pipeline");

  a_load_no_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_xfer && op == OP_LOAD) |=> !v1_q)
    else $error("load transfer occupied the phase stage");

  a_stalled_read_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !rdy2) |-> !s_axis_tready)
    else $error("transfer taken while a node read is pending");

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(n_q) >= COUNT_MIN) && (32'(n_q) <= MAX_NODES))
    else $error("node count out of range");

  a_out_moves : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && !v5_q) |=> v5_q)
    else $error("finished point not moved to the output register");

endmodule
